FILE: rtl/core/string_intern_table_unit_assert.svh
// assertion helpers for the string intern table
`ifndef STRING_INTERN_TABLE_UNIT_ASSERT_SVH
`define STRING_INTERN_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is high
`define SIT_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define SIT_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sit_pkg.sv
// ---------------------------------------------------------------------------
// sit_pkg
// Field widths, operation codes and defaults of the string intern table.
// ---------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

  // field widths
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int OFFSET_W = 10;
  localparam int LIMIT_W  = 11;

  // default table size and limit register reset
  localparam int DEF_TABLE_BYTES = 1024;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  // action codes, any other code acts as lookup
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_UNIQUE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_NEW     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/core/string_intern_table_unit.sv
// ---------------------------------------------------------------------------
// string_intern_table_unit
// Packed table of zero-terminated strings with append, unique append and
// lookup, fed one character per word.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, action, char_byte): one character per
//   word; a zero character ends the string and its action picks the operation.
//   Non-zero characters are taken one per cycle while the block is idle.
//   Output channel (out_valid / out_stall, status, offset): one word per
//   string, held in an output register until taken.
//   A terminating word starts the operation: append copies the incoming
//   string into the table and then writes its terminator, a search walks
//   the table from offset 0 up to the fill position (one table byte a cycle
//   through the table memory read port, plus one bubble at each stored
//   terminator); unique append that misses runs both. The result then
//   moves into the output register.
//   While an operation runs the input is stalled; while the receiver stalls,
//   new characters are still taken, and a finished result waits in its own
//   register until the output register frees up.
//   Reset (synchronous, active high) empties the table, drops any partial
//   string and sets the limit register to 1024. Table memory needs no clear.
//   cfg_we / cfg_data write the table limit; write it only while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module string_intern_table_unit #(
  parameter int TABLE_BYTES = sit_pkg::DEF_TABLE_BYTES
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [sit_pkg::LIMIT_W-1:0]  cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [sit_pkg::ACTION_W-1:0] action,
  input  wire logic [sit_pkg::CHAR_W-1:0]   char_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [sit_pkg::STATUS_W-1:0]      status,
  output logic [sit_pkg::OFFSET_W-1:0]      offset
);
  import sit_pkg::*;

  // address width, and length width that holds TABLE_BYTES + 1
  localparam int AW = $clog2(TABLE_BYTES);
  localparam int LW = $clog2(TABLE_BYTES + 2);
  localparam int CW = (LW > LIMIT_W) ? LW : LIMIT_W;
  localparam logic [LW-1:0] TB_L   = LW'(TABLE_BYTES);
  localparam logic [LW-1:0] OVER_L = LW'(TABLE_BYTES + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_DONE   = 3'd3;

  logic [2:0]          state;
  logic [LIMIT_W-1:0]  table_limit;
  logic [LW-1:0]       fill_position;
  logic [LW-1:0]       incoming_length;
  logic [ACTION_W-1:0] op;

  // walk pointers: issue stage and compare stage
  logic [LW-1:0] rd_pos;
  logic [LW-1:0] rd_idx;
  logic          rd_valid;
  logic [LW-1:0] cmp_pos;
  logic [LW-1:0] cmp_idx;
  logic          cmp_valid;
  logic [LW-1:0] str_start;
  logic          match;

  // pending result
  logic [STATUS_W-1:0] res_status;
  logic [LW-1:0]       res_where;

  // memories and their read data
  logic [CHAR_W-1:0] table_mem [TABLE_BYTES];
  logic [CHAR_W-1:0] inc_mem [TABLE_BYTES];
  logic [CHAR_W-1:0] tbl_q;
  logic [CHAR_W-1:0] inc_q;

  logic              in_accept;
  logic [CW-1:0]     lim_wide;
  logic [LW-1:0]     lim;
  logic              tbl_we;
  logic [AW-1:0]     tbl_wa;
  logic [CHAR_W-1:0] tbl_wd;
  logic              inc_we;
  logic              walk_end;
  logic              term_now;
  logic              res_load;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // usable limit is the smaller of the register and the table size
  always_comb begin
    lim_wide = (CW'(table_limit) < CW'(TABLE_BYTES)) ? CW'(table_limit) : CW'(TABLE_BYTES);
    lim      = lim_wide[LW-1:0];
  end

  assign walk_end = !rd_valid && !cmp_valid;
  assign term_now = (state == S_APPEND) && walk_end && (fill_position < lim);
  assign inc_we   = in_accept && (char_byte != '0) && (incoming_length < TB_L);
  assign res_load = (state == S_DONE) && (!out_valid || !out_stall);

  // table write: copied byte or terminator
  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = fill_position[AW-1:0];
    tbl_wd = inc_q;
    if (state == S_APPEND) begin
      if (cmp_valid) begin
        tbl_we = 1'b1;
      end else if (term_now) begin
        tbl_we = 1'b1;
        tbl_wd = '0;
      end
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      table_mem[tbl_wa] <= tbl_wd;
    end
    tbl_q <= table_mem[rd_pos[AW-1:0]];
  end

  // incoming string memory
  always_ff @(posedge clk) begin
    if (inc_we) begin
      inc_mem[incoming_length[AW-1:0]] <= char_byte;
    end
    inc_q <= inc_mem[rd_idx[AW-1:0]];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      table_limit     <= LIMIT_RESET;
      fill_position   <= '0;
      incoming_length <= '0;
      rd_valid        <= 1'b0;
      cmp_valid       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        table_limit <= cfg_data;
      end
      // output register: load a finished result, or clear once taken
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (char_byte != '0) begin
              // collect one character, saturate past the table size
              if (incoming_length < TB_L) begin
                incoming_length <= incoming_length + 1'b1;
              end else begin
                incoming_length <= OVER_L;
              end
            end else begin
              op        <= action;
              cmp_valid <= 1'b0;
              rd_idx    <= '0;
              if (action == ACT_APPEND) begin
                state     <= S_APPEND;
                str_start <= fill_position;
                rd_pos    <= fill_position;
                rd_valid  <= (incoming_length != '0) && (fill_position < lim);
              end else begin
                state     <= S_SEARCH;
                str_start <= '0;
                rd_pos    <= '0;
                match     <= 1'b1;
                rd_valid  <= (fill_position != '0);
              end
            end
          end
        end

        S_SEARCH: begin
          if (cmp_valid && (tbl_q == '0)) begin
            if (match && (cmp_idx == incoming_length)) begin
              // complete stored string equals the incoming one
              res_status <= ST_FOUND;
              res_where  <= str_start;
              rd_valid   <= 1'b0;
              cmp_valid  <= 1'b0;
              state      <= S_DONE;
            end else begin
              // restart at the next stored string, drop the read in flight
              str_start <= cmp_pos + 1'b1;
              match     <= 1'b1;
              rd_pos    <= cmp_pos + 1'b1;
              rd_idx    <= '0;
              rd_valid  <= ((cmp_pos + 1'b1) < fill_position);
              cmp_valid <= 1'b0;
            end
          end else if (walk_end) begin
            // nothing matched
            if (op == ACT_UNIQUE) begin
              state     <= S_APPEND;
              str_start <= fill_position;
              rd_pos    <= fill_position;
              rd_idx    <= '0;
              rd_valid  <= (incoming_length != '0) && (fill_position < lim);
            end else begin
              res_status <= ST_ABSENT;
              res_where  <= '0;
              state      <= S_DONE;
            end
          end else begin
            if (cmp_valid && ((cmp_idx >= incoming_length) || (tbl_q != inc_q))) begin
              match <= 1'b0;
            end
            cmp_valid <= rd_valid;
            cmp_pos   <= rd_pos;
            cmp_idx   <= rd_idx;
            if (rd_valid) begin
              rd_pos   <= rd_pos + 1'b1;
              rd_idx   <= rd_idx + 1'b1;
              rd_valid <= ((rd_pos + 1'b1) < fill_position);
            end
          end
        end

        S_APPEND: begin
          if (walk_end) begin
            if (term_now) begin
              fill_position <= fill_position + 1'b1;
              res_status    <= ST_NEW;
              res_where     <= str_start;
            end else begin
              res_status <= ST_NO_ROOM;
              res_where  <= '0;
            end
            state <= S_DONE;
          end else begin
            // byte read last cycle is written at the fill position
            if (cmp_valid) begin
              fill_position <= fill_position + 1'b1;
            end
            cmp_valid <= rd_valid;
            if (rd_valid) begin
              rd_pos   <= rd_pos + 1'b1;
              rd_idx   <= rd_idx + 1'b1;
              rd_valid <= ((rd_idx + 1'b1) < incoming_length) && ((rd_pos + 1'b1) < lim);
            end
          end
        end

        S_DONE: begin
          if (res_load) begin
            status          <= res_status;
            offset          <= OFFSET_W'(res_where);
            incoming_length <= '0;
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `include "string_intern_table_unit_assert.svh"

  logic srch_cmp;
  logic res_failed;
  assign srch_cmp   = (state == S_SEARCH) && cmp_valid;
  assign res_failed = out_valid && ((status == ST_ABSENT) || (status == ST_NO_ROOM));

  `SIT_ASSERT_IMP(a_fill_in_range, clk, rst, 1'b1, fill_position <= TB_L, "fill past table")
  `SIT_ASSERT_IMP(a_len_in_range, clk, rst, 1'b1, incoming_length <= OVER_L, "length overflow")
  `SIT_ASSERT_IMP(a_search_in_fill, clk, rst, srch_cmp, cmp_pos < fill_position, "read past fill")
  `SIT_ASSERT_NXT(a_fill_on_append, clk, rst, state != S_APPEND, $stable(fill_position), "fill moved")
  `SIT_ASSERT_IMP(a_failed_offset_zero, clk, rst, res_failed, offset == '0, "offset on failure")

endmodule

`default_nettype wire

FILE: tb/sv/string_intern_checker.sv
// ---------------------------------------------------------------------------
// string_intern_checker
// Watches the channels of the string intern table, keeps its own copy of the
// table, predicts the status and offset of every string and compares them
// with the words that leave the block.
// ---------------------------------------------------------------------------
module string_intern_checker #(
  parameter int TABLE_BYTES = sit_pkg::DEF_TABLE_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [sit_pkg::LIMIT_W-1:0]  cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [sit_pkg::ACTION_W-1:0] action,
  input  logic [sit_pkg::CHAR_W-1:0]   char_byte,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [sit_pkg::STATUS_W-1:0] status,
  input  logic [sit_pkg::OFFSET_W-1:0] offset,
  output int                           open_results,
  output int                           error_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import sit_pkg::*;

  localparam int AW = $clog2(TABLE_BYTES);

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [OFFSET_W-1:0] off;
  } intern_result_t;

  // shadow copy of the table and of the string being received
  logic [CHAR_W-1:0]  stored_chars  [TABLE_BYTES];
  logic [CHAR_W-1:0]  pending_chars [TABLE_BYTES];
  int unsigned        fill_pos    = 0;
  int unsigned        pending_len = 0;
  logic [LIMIT_W-1:0] limit_reg   = LIMIT_RESET;

  intern_result_t result_q [$];

  int open_count     = 0;
  int mismatch_count = 0;

  assign open_results = open_count;
  assign error_count  = mismatch_count;

  // search the complete stored strings for one equal to the pending string
  function automatic bit find_string(output int unsigned where);
    int unsigned pos;
    int unsigned start;
    int unsigned k;
    int unsigned at;
    bit          same;
    where = 0;
    pos   = 0;
    while (pos < fill_pos) begin
      start = pos;
      while (pos < fill_pos && stored_chars[pos[AW-1:0]] != '0)
        pos++;
      // an unterminated tail is not a string
      if (pos >= fill_pos)
        return 1'b0;
      if (pos - start == pending_len) begin
        same = 1'b1;
        for (k = 0; k < pending_len; k++) begin
          at = start + k;
          if (stored_chars[at[AW-1:0]] != pending_chars[k[AW-1:0]])
            same = 1'b0;
        end
        if (same) begin
          where = start;
          return 1'b1;
        end
      end
      pos++;
    end
    return 1'b0;
  endfunction

  // copy the pending string into the table; truncates when room runs out
  function automatic bit store_string(output int unsigned where);
    int unsigned lim;
    int unsigned start;
    int unsigned k;
    lim   = (limit_reg < TABLE_BYTES) ? int'(limit_reg) : TABLE_BYTES;
    start = fill_pos;
    k     = 0;
    where = 0;
    while (fill_pos < lim && k < pending_len) begin
      stored_chars[fill_pos[AW-1:0]] = pending_chars[k[AW-1:0]];
      fill_pos++;
      k++;
    end
    if (fill_pos < lim) begin
      stored_chars[fill_pos[AW-1:0]] = '0;
      fill_pos++;
      where = start;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // one accepted input word
  task automatic predict_word(input logic [ACTION_W-1:0] act,
                              input logic [CHAR_W-1:0] ch);
    int unsigned         where;
    logic [STATUS_W-1:0] st;
    intern_result_t      res;
    if (ch != '0) begin
      // length saturates one past the table size
      if (pending_len < TABLE_BYTES) begin
        pending_chars[pending_len[AW-1:0]] = ch;
        pending_len++;
      end else begin
        pending_len = TABLE_BYTES + 1;
      end
    end else begin
      if (act == ACT_APPEND) begin
        st = store_string(where) ? ST_NEW : ST_NO_ROOM;
      end else if (act == ACT_UNIQUE) begin
        if (find_string(where))
          st = ST_FOUND;
        else
          st = store_string(where) ? ST_NEW : ST_NO_ROOM;
      end else begin
        st = find_string(where) ? ST_FOUND : ST_ABSENT;
      end
      if (st == ST_ABSENT || st == ST_NO_ROOM)
        where = 0;
      res.st  = st;
      res.off = where[OFFSET_W-1:0];
      result_q.push_back(res);
      pending_len = 0;
    end
  endtask

  // one accepted output word against the oldest prediction
  task automatic compare_word();
    intern_result_t exp_res;
    if (result_q.size() == 0) begin
      mismatch_count <= mismatch_count + 1;
      if (mismatch_count < 10)
        $display("%0t: unexpected result word status %0d offset %0d",
                 $realtime, status, offset);
    end else begin
      exp_res = result_q.pop_front();
      if (status !== exp_res.st || offset !== exp_res.off) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10)
          $display("%0t: mismatch status exp %0d got %0d, offset exp %0d got %0d",
                   $realtime, exp_res.st, status, exp_res.off, offset);
      end
    end
  endtask

  // sample both channels and the register port at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      fill_pos    = 0;
      pending_len = 0;
      limit_reg   = LIMIT_RESET;
      result_q.delete();
    end else begin
      if (cfg_we)
        limit_reg = cfg_data;
      if (in_valid && !in_stall)
        predict_word(action, char_byte);
      if (out_valid && !out_stall)
        compare_word();
    end
    open_count <= result_q.size();
  end

endmodule

FILE: tb/sv/tb_string_intern_table_unit.sv
// ---------------------------------------------------------------------------
// tb_string_intern_table_unit
// Drives strings into the string intern table: a directed opening over the
// operations and table-full cases, then random phases with several limits and
// idle patterns, and a receiver hold-off. The checker beside the block
// predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_string_intern_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sit_pkg::*;

  // spare action code, behaves as lookup
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
  localparam int HIST_DEPTH = 64;
  localparam int HIST_LEN   = 8;
  localparam int HA         = $clog2(HIST_DEPTH);
  localparam int HL         = $clog2(HIST_LEN);
  localparam int CHARS_MAX  = 24;
  localparam int CA         = $clog2(CHARS_MAX);
  localparam int DRAIN_CYCLES = 2500;

  logic                clk;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [LIMIT_W-1:0]  cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [ACTION_W-1:0] action    = '0;
  logic [CHAR_W-1:0]   char_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [OFFSET_W-1:0] offset;

  int open_results;
  int error_count;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int phase_words   = 0;

  // recent strings, replayed so that searches hit
  logic [CHAR_W-1:0] hist_chars [HIST_DEPTH][HIST_LEN];
  int                hist_len   [HIST_DEPTH];
  int                hist_count = 0;
  int                hist_wr    = 0;

  string_intern_table_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .char_byte (char_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .offset    (offset)
  );

  string_intern_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .char_byte    (char_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .offset       (offset),
    .open_results (open_results),
    .error_count  (error_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #160ms;
    $display("Verification failed");
    $finish;
  end

  // receiver: random stall, or a long hold-off when asked
  initial begin
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      if (holds_seen != hold_requests) begin
        hold_left  = 400;
        holds_seen = hold_requests;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // offer one word, with random idle cycles ahead of it; starts and ends on
  // a falling edge
  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [CHAR_W-1:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid  <= 1'b0;
      action    <= ACTION_W'($urandom_range(3));
      char_byte <= CHAR_W'($urandom_range(255));
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    char_byte <= ch;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    phase_words++;
  endtask

  // text characters then the terminating word
  task automatic send_text(input string s, input logic [ACTION_W-1:0] act);
    int k;
    for (k = 0; k < s.len(); k++)
      send_word(ACTION_W'($urandom_range(3)), s[k]);
    send_word(act, 8'h00);
  endtask

  // hold the sender until every predicted result has left the block
  task automatic wait_results();
    in_valid <= 1'b0;
    while (open_results != 0)
      @(negedge clk);
  endtask

  // block idle: no result open and no character still in flight
  task automatic wait_quiet();
    wait_results();
    repeat (16) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // replayed, fresh or noise string with a random operation
  task automatic send_random_string();
    logic [CHAR_W-1:0]   chars [CHARS_MAX];
    logic [ACTION_W-1:0] act;
    int len;
    int pick;
    int k;
    int roll;
    roll = $urandom_range(99);
    if (hist_count > 0 && roll < 45) begin
      pick = $urandom_range(hist_count - 1);
      len  = hist_len[pick[HA-1:0]];
      for (k = 0; k < len; k++)
        chars[k[CA-1:0]] = hist_chars[pick[HA-1:0]][k[HL-1:0]];
    end else if (roll < 55) begin
      // noise: longer strings over the full byte range
      len = $urandom_range(9, CHARS_MAX);
      for (k = 0; k < len; k++)
        chars[k[CA-1:0]] = CHAR_W'($urandom_range(1, 255));
    end else begin
      len = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, HIST_LEN);
      for (k = 0; k < len; k++)
        chars[k[CA-1:0]] = ($urandom_range(99) < 60) ? CHAR_W'(8'h61 + $urandom_range(3))
                                                     : CHAR_W'($urandom_range(1, 255));
      for (k = 0; k < len; k++)
        hist_chars[hist_wr[HA-1:0]][k[HL-1:0]] = chars[k[CA-1:0]];
      hist_len[hist_wr[HA-1:0]] = len;
      hist_wr = (hist_wr + 1) % HIST_DEPTH;
      if (hist_count < HIST_DEPTH)
        hist_count++;
    end
    roll = $urandom_range(99);
    if (roll < 25)
      act = ACT_APPEND;
    else if (roll < 60)
      act = ACT_UNIQUE;
    else if (roll < 90)
      act = ACT_LOOKUP;
    else
      act = ACT_SPARE;
    for (k = 0; k < len; k++)
      send_word(ACTION_W'($urandom_range(3)), chars[k[CA-1:0]]);
    send_word(act, 8'h00);
  endtask

  // one random phase at a given limit and idle pattern
  task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int idle_pct,
                           input int stall, input int words, input int pause_at,
                           input bit hold);
    bit paused;
    paused = 1'b0;
    wait_quiet();
    write_limit(limit);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    phase_words   = 0;
    if (hold)
      hold_requests++;
    while (phase_words < words) begin
      if (!paused && pause_at >= 0 && phase_words >= pause_at) begin
        wait_results();
        paused = 1'b1;
      end
      send_random_string();
    end
  endtask

  // stimulus and verdict
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: every operation on an empty and a growing table
    write_limit(LIMIT_RESET);
    send_word(ACT_APPEND, 8'h00);
    send_word(ACTION_W'($urandom_range(3)), 8'h01);
    send_word(ACTION_W'($urandom_range(3)), 8'hFF);
    send_word(ACT_APPEND, 8'h00);
    send_word(ACTION_W'($urandom_range(3)), 8'h01);
    send_word(ACTION_W'($urandom_range(3)), 8'hFF);
    send_word(ACT_UNIQUE, 8'h00);
    send_text("x", ACT_LOOKUP);
    send_text("x", ACT_SPARE);
    send_word(ACT_UNIQUE, 8'h00);
    send_text("x", ACT_UNIQUE);
    send_text("x", ACT_APPEND);
    send_text("x", ACT_LOOKUP);

    // directed: a string that fills the table right up to the limit, then a lookup of its prefix
    wait_quiet();
    write_limit(11'd14);
    send_text("hello", ACT_APPEND);
    send_text("he", ACT_LOOKUP);

    // directed: limit below the fill position
    wait_quiet();
    write_limit(11'd4);
    send_word(ACT_APPEND, 8'h00);

    // random phases
    run_phase(LIMIT_RESET, 0, 0, 220, -1, 1'b0);
    run_phase(LIMIT_W'($urandom_range(150, 400)), 50, 0, 220, 110, 1'b0);
    run_phase(11'd1, 0, 50, 220, -1, 1'b0);
    run_phase(LIMIT_RESET, 11, 11, 220, -1, 1'b1);
    run_phase(LIMIT_W'($urandom_range(1, 1024)), 50, 50, 200, -1, 1'b0);

    // drain
    in_valid <= 1'b0;
    while (open_results != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/sit_pkg.sv
rtl/core/string_intern_table_unit.sv
tb/sv/string_intern_checker.sv
tb/sv/tb_string_intern_table_unit.sv
